// File: sv/complex_arithmetic_unit_top_assert.svh
// assertion macros for the complex arithmetic unit
// used by complex_arithmetic_unit_top, expects a clock aclk and reset aresetn
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("complex arithmetic unit check failed");

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("complex arithmetic unit check failed");

`endif

// File: sv/cau_pkg.sv
// shared types, codes, tables and helpers of the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_POLAR = 3'd4;

    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 32;
    localparam int CORDIC_MAX = 32;
    localparam int NUM_CELLS  = 33;
    localparam int XY_GUARD   = 28;
    localparam int ANGLE_FRAC = 24;

    localparam int unsigned ATAN_DEG [0:31] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    localparam logic signed [35:0] HALF_TURN = 36'sd3019898880;

    typedef struct packed {
        logic [2:0]         op;
        logic               pre_sat;
        logic [31:0]        pre_re;
        logic [31:0]        pre_im;
        logic               ar_pos;
        logic               ar_zero;
        logic [63:0]        d;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        logic [63:0]        rem_re;
        logic [63:0]        rem_im;
        logic [32:0]        mlo_re;
        logic [32:0]        mlo_im;
        logic [32:0]        q_re;
        logic [32:0]        q_im;
        logic [63:0]        sq_n;
        logic [63:0]        sq_res;
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [35:0] cz;
    } cau_item_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } cau_sat_t;

    function automatic cau_sat_t cau_sat32(input logic signed [71:0] v);
        cau_sat_t r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 72'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v < -72'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/cau_prep.sv
// operand front end: products, sums, add/sub/mul results and iteration setup
// depends on cau_pkg
`timescale 1ns / 1ps
`default_nettype none

module cau_prep #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          in_op,
    input  wire logic signed [31:0]  in_ar,
    input  wire logic signed [31:0]  in_ai,
    input  wire logic signed [31:0]  in_br,
    input  wire logic signed [31:0]  in_bi,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output cau_pkg::cau_item_t       out_item
);
    import cau_pkg::*;

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1
    logic [2:0]         op1_reg;
    logic signed [63:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [63:0] pbr_reg, pbi_reg, par_reg, pai_reg;
    logic signed [32:0] as_re1_reg, as_im1_reg;
    logic signed [63:0] cx1_reg, cy1_reg;
    logic               ar_pos1_reg, ar_zero1_reg;
    logic signed [32:0] ar_abs;
    logic signed [32:0] as_re_next, as_im_next;

    // stage 2
    logic [2:0]         op2_reg;
    logic signed [64:0] nre2_reg, nim2_reg;
    logic [63:0]        d2_reg, sqn2_reg;
    logic signed [65:0] mre2_reg, mim2_reg;
    logic signed [32:0] as_re2_reg, as_im2_reg;
    logic signed [63:0] cx2_reg, cy2_reg;
    logic               ar_pos2_reg, ar_zero2_reg;

    // stage 3
    cau_item_t          item_reg, item_next;
    logic [63:0]        abs_re, abs_im;
    logic [87:0]        m_re, m_im;
    logic [63:0]        rin_re, rin_im;
    cau_sat_t           s_re, s_im;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_comb begin
        ar_abs = in_ar[31] ? -33'(in_ar) : 33'(in_ar);
        if (in_op == OP_SUB) begin
            as_re_next = 33'(in_ar) - 33'(in_br);
            as_im_next = 33'(in_ai) - 33'(in_bi);
        end else begin
            as_re_next = 33'(in_ar) + 33'(in_br);
            as_im_next = 33'(in_ai) + 33'(in_bi);
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg      <= in_op;
            prr_reg      <= in_ar * in_br;
            pii_reg      <= in_ai * in_bi;
            pri_reg      <= in_ar * in_bi;
            pir_reg      <= in_ai * in_br;
            pbr_reg      <= in_br * in_br;
            pbi_reg      <= in_bi * in_bi;
            par_reg      <= in_ar * in_ar;
            pai_reg      <= in_ai * in_ai;
            as_re1_reg   <= as_re_next;
            as_im1_reg   <= as_im_next;
            cx1_reg      <= 64'(ar_abs) <<< XY_GUARD;
            cy1_reg      <= 64'(in_ai) <<< XY_GUARD;
            ar_pos1_reg  <= !in_ar[31] && (in_ar != 32'sd0);
            ar_zero1_reg <= (in_ar == 32'sd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            op2_reg      <= op1_reg;
            nre2_reg     <= 65'(prr_reg) + 65'(pii_reg);
            nim2_reg     <= 65'(pir_reg) - 65'(pri_reg);
            d2_reg       <= 64'(pbr_reg) + 64'(pbi_reg);
            sqn2_reg     <= 64'(par_reg) + 64'(pai_reg);
            mre2_reg     <= 66'(prr_reg) - 66'(pii_reg) + HALF;
            mim2_reg     <= 66'(pri_reg) + 66'(pir_reg) + HALF;
            as_re2_reg   <= as_re1_reg;
            as_im2_reg   <= as_im1_reg;
            cx2_reg      <= cx1_reg;
            cy2_reg      <= cy1_reg;
            ar_pos2_reg  <= ar_pos1_reg;
            ar_zero2_reg <= ar_zero1_reg;
        end
    end

    always_comb begin
        abs_re = nre2_reg[64] ? 64'(-nre2_reg) : 64'(nre2_reg);
        abs_im = nim2_reg[64] ? 64'(-nim2_reg) : 64'(nim2_reg);
        m_re   = {24'd0, abs_re} << FRAC_BITS;
        m_im   = {24'd0, abs_im} << FRAC_BITS;
        rin_re = {9'd0, m_re[87:33]};
        rin_im = {9'd0, m_im[87:33]};
        if (op2_reg == OP_MUL) begin
            s_re = cau_sat32(72'(mre2_reg >>> FRAC_BITS));
            s_im = cau_sat32(72'(mim2_reg >>> FRAC_BITS));
        end else begin
            s_re = cau_sat32(72'(as_re2_reg));
            s_im = cau_sat32(72'(as_im2_reg));
        end

        item_next         = '0;
        item_next.op      = op2_reg;
        item_next.pre_sat = s_re.sat || s_im.sat;
        item_next.pre_re  = s_re.val;
        item_next.pre_im  = s_im.val;
        item_next.ar_pos  = ar_pos2_reg;
        item_next.ar_zero = ar_zero2_reg;
        item_next.d       = d2_reg;
        item_next.neg_re  = nre2_reg[64];
        item_next.neg_im  = nim2_reg[64];
        item_next.ovf_re  = rin_re >= d2_reg;
        item_next.ovf_im  = rin_im >= d2_reg;
        item_next.rem_re  = rin_re;
        item_next.rem_im  = rin_im;
        item_next.mlo_re  = m_re[32:0];
        item_next.mlo_im  = m_im[32:0];
        item_next.sq_n    = sqn2_reg;
        item_next.cx      = cx2_reg;
        item_next.cy      = cy2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// File: sv/cau_cell.sv
// one iteration cell: a quotient bit for both divide parts, a root step and
// a rotation step if STEP allows, then the beat moves on; depends on cau_pkg
`timescale 1ns / 1ps
`default_nettype none

module cau_cell #(
    parameter int STEP         = 0,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  cau_pkg::cau_item_t in_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output cau_pkg::cau_item_t out_item
);
    import cau_pkg::*;

    localparam int           MBIT     = DIV_STEPS - 1 - STEP;
    localparam bit           DO_SQRT  = STEP < SQRT_STEPS;
    localparam bit           DO_ROT   = (STEP < CORDIC_STEPS) && (STEP < CORDIC_MAX);
    localparam int           SQ_SHIFT = DO_SQRT ? 62 - 2 * STEP : 0;
    localparam logic [63:0]  SQ_BIT   = 64'd1 << SQ_SHIFT;
    localparam int           ROT_SH   = DO_ROT ? STEP : 0;
    localparam logic signed [35:0] ATAN_STEP = $signed({4'd0, ATAN_DEG[ROT_SH]});

    logic        valid_reg;
    cau_item_t   item_reg, item_next;
    logic [63:0] t_re, t_im, trial;
    logic        qb_re, qb_im;
    logic signed [63:0] dx, dy;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next = in_item;

        t_re  = {in_item.rem_re[62:0], in_item.mlo_re[MBIT]};
        t_im  = {in_item.rem_im[62:0], in_item.mlo_im[MBIT]};
        qb_re = t_re >= in_item.d;
        qb_im = t_im >= in_item.d;
        item_next.rem_re = qb_re ? t_re - in_item.d : t_re;
        item_next.rem_im = qb_im ? t_im - in_item.d : t_im;
        item_next.q_re   = {in_item.q_re[31:0], qb_re};
        item_next.q_im   = {in_item.q_im[31:0], qb_im};

        trial = in_item.sq_res + SQ_BIT;
        if (DO_SQRT) begin
            if (in_item.sq_n >= trial) begin
                item_next.sq_n   = in_item.sq_n - trial;
                item_next.sq_res = (in_item.sq_res >> 1) + SQ_BIT;
            end else begin
                item_next.sq_res = in_item.sq_res >> 1;
            end
        end

        dx = in_item.cy >>> ROT_SH;
        dy = in_item.cx >>> ROT_SH;
        if (DO_ROT) begin
            if (!in_item.cy[63]) begin
                item_next.cx = in_item.cx + dx;
                item_next.cy = in_item.cy - dy;
                item_next.cz = in_item.cz + ATAN_STEP;
            end else begin
                item_next.cx = in_item.cx - dx;
                item_next.cy = in_item.cy + dy;
                item_next.cz = in_item.cz - ATAN_STEP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// File: sv/cau_final.sv
// result stage: quotient rounding, root rounding, angle fold, selection by
// opcode and the output register; depends on cau_pkg
`timescale 1ns / 1ps
`default_nettype none

module cau_final #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  cau_pkg::cau_item_t in_item,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        out_re,
    output logic [31:0]        out_im,
    output logic               out_err,
    output logic               out_sat
);
    import cau_pkg::*;

    localparam int SH = ANGLE_FRAC - FRAC_BITS;
    localparam logic signed [35:0] ANG_HALF = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;

    logic        valid_reg;
    logic [31:0] re_reg, im_reg, re_next, im_next;
    logic        err_reg, sat_reg, err_next, sat_next;

    cau_sat_t    dv_re, dv_im, ang;
    logic [64:0] mag;
    logic        mag_sat;
    logic signed [35:0] ang_raw, ang_rnd;

    function automatic cau_sat_t div_fix(input logic [32:0] q, input logic [63:0] rem,
                                         input logic [63:0] d, input logic neg,
                                         input logic ovf);
        cau_sat_t    r;
        logic [33:0] qr;
        qr = {1'b0, q} + (({rem, 1'b0} >= {1'b0, d}) ? 34'd1 : 34'd0);
        r.sat = 1'b0;
        r.val = neg ? 32'(-qr) : qr[31:0];
        if (ovf || (!neg && qr > 34'h0_7FFF_FFFF) || (neg && qr > 34'h0_8000_0000)) begin
            r.sat = 1'b1;
            r.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        dv_re = div_fix(in_item.q_re, in_item.rem_re, in_item.d, in_item.neg_re,
                        in_item.ovf_re);
        dv_im = div_fix(in_item.q_im, in_item.rem_im, in_item.d, in_item.neg_im,
                        in_item.ovf_im);

        mag     = {1'b0, in_item.sq_res} + ((in_item.sq_n > in_item.sq_res) ? 65'd1 : 65'd0);
        mag_sat = mag > 65'h0_7FFF_FFFF;

        ang_raw = in_item.ar_pos ? in_item.cz : HALF_TURN - in_item.cz;
        ang_rnd = (ang_raw + ANG_HALF) >>> SH;
        ang     = cau_sat32(72'(ang_rnd));

        re_next  = 32'd0;
        im_next  = 32'd0;
        err_next = 1'b0;
        sat_next = 1'b0;
        unique case (in_item.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                re_next  = in_item.pre_re;
                im_next  = in_item.pre_im;
                sat_next = in_item.pre_sat;
            end
            OP_DIV: begin
                if (in_item.d == 64'd0) begin
                    err_next = 1'b1;
                end else begin
                    re_next  = dv_re.val;
                    im_next  = dv_im.val;
                    sat_next = dv_re.sat || dv_im.sat;
                end
            end
            OP_POLAR: begin
                re_next  = mag_sat ? 32'h7FFF_FFFF : mag[31:0];
                err_next = in_item.ar_zero;
                im_next  = in_item.ar_zero ? 32'd0 : ang.val;
                sat_next = mag_sat || (!in_item.ar_zero && ang.sat);
            end
            default: begin
                err_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            err_reg <= err_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;
    assign out_err   = err_reg;
    assign out_sat   = sat_reg;

endmodule

`default_nettype wire

// File: sv/complex_arithmetic_unit_top.sv
// complex arithmetic unit top level: front end, row of iteration cells, result stage
// depends on cau_pkg, cau_prep, cau_cell, cau_final and the assertion header
//
//  channel  dir  tdata                                  tuser
//  s_       in   a_re, a_im, b_re, b_im (128 bits)      opcode (3 bits)
//  m_       out  res_re, res_im (64 bits)               math_error, saturated
//
// one beat per cycle sustained while m_tready is high
// the row length is set by the 33 quotient bits, one per cell of the row
// reset clears only the stage valid bits, payload registers are not reset
// every stage holds its beat while the one after it is full and stalled,
// so input is taken as long as any stage down the row has room
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  wire logic [2:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // res_re, res_im
    output logic [1:0]        m_tuser    // math_error, saturated
);
    import cau_pkg::*;

    `include "complex_arithmetic_unit_top_assert.svh"

    cau_item_t              row_item  [NUM_CELLS + 1];
    logic [NUM_CELLS:0]     row_valid;
    logic [NUM_CELLS:0]     row_ready;
    logic [31:0]            res_re, res_im;
    logic                   res_err, res_sat;

    cau_prep #(
        .FRAC_BITS(FRAC_BITS)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_ar     ($signed(s_tdata[31:0])),
        .in_ai     ($signed(s_tdata[63:32])),
        .in_br     ($signed(s_tdata[95:64])),
        .in_bi     ($signed(s_tdata[127:96])),
        .out_valid (row_valid[0]),
        .out_ready (row_ready[0]),
        .out_item  (row_item[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        cau_cell #(
            .STEP        (g),
            .CORDIC_STEPS(CORDIC_STEPS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (row_valid[g]),
            .in_ready  (row_ready[g]),
            .in_item   (row_item[g]),
            .out_valid (row_valid[g + 1]),
            .out_ready (row_ready[g + 1]),
            .out_item  (row_item[g + 1])
        );
    end

    cau_final #(
        .FRAC_BITS(FRAC_BITS)
    ) u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (row_valid[NUM_CELLS]),
        .in_ready  (row_ready[NUM_CELLS]),
        .in_item   (row_item[NUM_CELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_re    (res_re),
        .out_im    (res_im),
        .out_err   (res_err),
        .out_sat   (res_sat)
    );

    assign m_tdata = {res_im, res_re};
    assign m_tuser = {res_sat, res_err};

    `CAU_ASSERT_NOW(a_err_zero_im, m_tvalid && m_tuser[0], m_tdata[63:32] == 32'd0)
    `CAU_ASSERT_NOW(a_sat_clamped, m_tvalid && m_tuser[1],
        m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
        m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000)
    `CAU_ASSERT_NOW(a_stall_only_full, !s_tready, m_tvalid && !m_tready)
    `CAU_ASSERT_NOW(a_ready_passes, m_tready, s_tready)

endmodule

`default_nettype wire
